// File: sv/mpp_pkg.sv
`default_nettype none

package mpp_pkg;

    // Widths fixed by the item fields and registers
    localparam int READING_W = 12;
    localparam int VEL_W     = 16;
    localparam int ADV_W     = 24;
    localparam int CFG_W     = 8;

    // Register indexes on the configuration port
    localparam logic CFG_ADJUST_STEP   = 1'b0;
    localparam logic CFG_ADVANCE_RATIO = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] ADJUST_STEP_RST   = 8'd5;
    localparam logic [CFG_W-1:0] ADVANCE_RATIO_RST = 8'd0;

    // Item kinds
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_FRESH = 2'd1,
        FUNC_INIT  = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // One input request
    typedef struct packed {
        t_func                func;
        logic [READING_W-1:0] reading;
    } t_req;

    // Configuration register contents
    typedef struct packed {
        logic [CFG_W-1:0] adjust_step;
        logic [CFG_W-1:0] advance_ratio;
    } t_cfg;

endpackage

`default_nettype wire

// File: sv/mpp_core.sv
`default_nettype none

module mpp_core #(
    parameter int PHASE_BITS           = 10,
    parameter int FRACTION_BITS        = 8,
    parameter int STEPS_PER_ROTATION   = 4096,
    parameter int PREDICTS_PER_READING = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_fire,
    input  wire mpp_pkg::t_req                     i_req,
    input  wire mpp_pkg::t_cfg                     i_cfg,
    output logic            [PHASE_BITS-1:0]       o_phase,
    output logic signed     [mpp_pkg::VEL_W-1:0]   o_velocity
);

    localparam int ACC_BITS = PHASE_BITS + FRACTION_BITS;
    localparam int RD_W     = mpp_pkg::READING_W;
    localparam int VEL_W    = mpp_pkg::VEL_W;
    localparam int ADV_W    = mpp_pkg::ADV_W;
    localparam int STEP_B   = $clog2(STEPS_PER_ROTATION) + 1;
    // signed change must hold reading difference plus one rotation
    localparam int CHG_W    = ((RD_W > STEP_B) ? RD_W : STEP_B) + 2;
    // velocity times predictions per reading (count fits in 8 signed bits)
    localparam int PRD_W    = VEL_W + 8;
    localparam int CMP_W    = (CHG_W > PRD_W) ? CHG_W : PRD_W;
    localparam int NDG_W    = VEL_W + 2;

    localparam logic signed [CHG_W-1:0] HALF_ROT  = CHG_W'(STEPS_PER_ROTATION / 2);
    localparam logic signed [CHG_W-1:0] FULL_ROT  = CHG_W'(STEPS_PER_ROTATION);
    localparam logic signed [PRD_W-1:0] PRED_MULT = PRD_W'(PREDICTS_PER_READING);
    localparam logic signed [NDG_W-1:0] VEL_MAX   = NDG_W'(32767);
    localparam logic signed [NDG_W-1:0] VEL_MIN   = -NDG_W'(32768);

    // Predictor state
    logic        [ACC_BITS-1:0]   r_acc,       n_acc;
    logic        [RD_W-1:0]       r_last_mech, n_last_mech;
    logic signed [VEL_W-1:0]      r_vel,       n_vel;
    logic signed [ADV_W-1:0]      r_adv,       n_adv;
    logic        [PHASE_BITS-1:0] r_last_pred, n_last_pred;

    // Tick path
    logic [ACC_BITS-1:0] tick_acc;
    logic [ACC_BITS-1:0] tick_adv;

    // Reading path
    logic        [ACC_BITS-1:0] resync_acc;
    logic        [31:0]         resync_wide;
    logic signed [CHG_W-1:0]    chg_raw;
    logic signed [CHG_W-1:0]    chg;
    logic signed [PRD_W-1:0]    pred_prod;
    logic signed [PRD_W-1:0]    pred_chg;
    logic signed [NDG_W-1:0]    adj_ext;
    logic signed [NDG_W-1:0]    vel_nudge;
    logic signed [VEL_W-1:0]    vel_sat;
    logic signed [ADV_W-1:0]    ratio_ext;

    // Tick: advance accumulator by velocity, then add phase advance
    always_comb begin
        tick_acc = r_acc + ACC_BITS'(r_vel);
        tick_adv = tick_acc + ACC_BITS'(r_adv);
    end

    // Reading: wrapped mechanical change against predicted change
    always_comb begin
        resync_wide = 32'(i_req.reading) << FRACTION_BITS;
        resync_acc  = resync_wide[ACC_BITS-1:0];

        chg_raw = CHG_W'($signed({1'b0, i_req.reading}))
                - CHG_W'($signed({1'b0, r_last_mech}));
        if (chg_raw > HALF_ROT) begin
            chg = chg_raw - FULL_ROT;
        end else if (chg_raw < -HALF_ROT) begin
            chg = chg_raw + FULL_ROT;
        end else begin
            chg = chg_raw;
        end

        pred_prod = PRD_W'(r_vel) * PRED_MULT;
        pred_chg  = pred_prod >>> FRACTION_BITS;

        adj_ext = NDG_W'($signed({1'b0, i_cfg.adjust_step}));
        if (CMP_W'(chg) > CMP_W'(pred_chg)) begin
            vel_nudge = NDG_W'(r_vel) + adj_ext;
        end else if (CMP_W'(chg) < CMP_W'(pred_chg)) begin
            vel_nudge = NDG_W'(r_vel) - adj_ext;
        end else begin
            vel_nudge = NDG_W'(r_vel);
        end

        if (vel_nudge > VEL_MAX) begin
            vel_sat = VEL_W'(VEL_MAX);
        end else if (vel_nudge < VEL_MIN) begin
            vel_sat = VEL_W'(VEL_MIN);
        end else begin
            vel_sat = VEL_W'(vel_nudge);
        end

        ratio_ext = ADV_W'($signed({1'b0, i_cfg.advance_ratio}));
    end

    // Next state per item kind
    always_comb begin
        n_acc       = r_acc;
        n_last_mech = r_last_mech;
        n_vel       = r_vel;
        n_adv       = r_adv;
        n_last_pred = r_last_pred;
        unique case (i_req.func)
            mpp_pkg::FUNC_TICK: begin
                n_acc       = tick_acc;
                n_last_pred = tick_adv[ACC_BITS-1:FRACTION_BITS];
            end
            mpp_pkg::FUNC_FRESH: begin
                n_vel       = vel_sat;
                n_acc       = resync_acc;
                n_adv       = ADV_W'(vel_sat) * ratio_ext;
                n_last_mech = i_req.reading;
            end
            mpp_pkg::FUNC_INIT: begin
                n_vel       = '0;
                n_acc       = resync_acc;
                n_last_mech = i_req.reading;
            end
            mpp_pkg::FUNC_NOP: begin
                n_acc = r_acc;
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_last_mech <= '0;
            r_vel       <= '0;
            r_adv       <= '0;
            r_last_pred <= '0;
        end else if (i_fire) begin
            r_acc       <= n_acc;
            r_last_mech <= n_last_mech;
            r_vel       <= n_vel;
            r_adv       <= n_adv;
            r_last_pred <= n_last_pred;
        end
    end

    assign o_phase    = n_last_pred;
    assign o_velocity = n_vel;

endmodule

`default_nettype wire

// File: sv/motor_phase_predictor.sv
`default_nettype none

// Channel   | Handshake                 | Payload
// ----------+---------------------------+--------------------------------------
// input     | i_in_valid / o_in_ready   | i_func, i_reading
// result    | o_out_valid / i_out_ready | o_predicted_phase, o_velocity
// config    | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// One request per clock sustained while the result is not stalled; a request's
// result passes the input register, then the result register, to the outputs.
// All arithmetic for a request sits between the input register and the
// result register; the fresh-reading path (compare, nudge, 16x8 multiply)
// sets the cycle time.
// Synchronous active-low reset clears state; registers return to defaults.
// A stalled result holds the input register; the input side stays open while
// the input register is empty.

module motor_phase_predictor #(
    parameter int PHASE_BITS           = 10,
    parameter int FRACTION_BITS        = 8,
    parameter int STEPS_PER_ROTATION   = 4096,
    parameter int PREDICTS_PER_READING = 4
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire logic [1:0]                              i_func,
    input  wire logic [mpp_pkg::READING_W-1:0]           i_reading,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic        [PHASE_BITS-1:0]                 o_predicted_phase,
    output logic signed [mpp_pkg::VEL_W-1:0]             o_velocity,
    input  wire logic                                    i_cfg_we,
    input  wire logic                                    i_cfg_index,
    input  wire logic [mpp_pkg::CFG_W-1:0]               i_cfg_data
);

    mpp_pkg::t_cfg r_cfg;
    mpp_pkg::t_req r_in;
    logic          r_in_valid;
    logic          advance;

    logic        [PHASE_BITS-1:0]     core_phase;
    logic signed [mpp_pkg::VEL_W-1:0] core_vel;

    logic        [PHASE_BITS-1:0]     r_out_phase;
    logic signed [mpp_pkg::VEL_W-1:0] r_out_vel;
    logic                             r_out_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.adjust_step   <= mpp_pkg::ADJUST_STEP_RST;
            r_cfg.advance_ratio <= mpp_pkg::ADVANCE_RATIO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mpp_pkg::CFG_ADJUST_STEP:   r_cfg.adjust_step   <= i_cfg_data;
                mpp_pkg::CFG_ADVANCE_RATIO: r_cfg.advance_ratio <= i_cfg_data;
                default:                    r_cfg               <= r_cfg;
            endcase
        end
    end

    // Request moves to the result register when that is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.func    <= mpp_pkg::t_func'(i_func);
            r_in.reading <= i_reading;
        end
    end

    // Predictor state and arithmetic
    mpp_core #(
        .PHASE_BITS           (PHASE_BITS),
        .FRACTION_BITS        (FRACTION_BITS),
        .STEPS_PER_ROTATION   (STEPS_PER_ROTATION),
        .PREDICTS_PER_READING (PREDICTS_PER_READING)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_req      (r_in),
        .i_cfg      (r_cfg),
        .o_phase    (core_phase),
        .o_velocity (core_vel)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_phase <= core_phase;
            r_out_vel   <= core_vel;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_predicted_phase = r_out_phase;
    assign o_velocity        = r_out_vel;

    // Init request always reports zero velocity
    a_init_clears_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in.func == mpp_pkg::FUNC_INIT) |=> (o_velocity == '0))
        else $error("init request did not clear velocity");

    // A waiting request is held until it moves on
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("input register lost a waiting request");

    // A stalled result keeps its value
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_vel)
            && $stable(r_out_phase))
        else $error("result register changed while stalled");

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
